// ===== hdl/pprc_pkg.sv =====
// shared types, constants and the word slot table for the palette port
// no dependencies
package pprc_pkg;

  localparam int unsigned PALETTE_WORDS = 256;
  localparam int unsigned SLOT_W        = (PALETTE_WORDS > 2) ? $clog2(PALETTE_WORDS) : 1;
  localparam int unsigned WORD_W        = 15;
  localparam int unsigned ADDR_W        = 9;
  localparam int unsigned INDEX_SPAN    = 256;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef slot_t [INDEX_SPAN-1:0] slot_tab_t;

  // word index to store slot; each index maps onto its own slot
  function automatic slot_tab_t build_slot_tab();
    slot_tab_t t;
    for (int i = 0; i < INDEX_SPAN; i++) begin
      t[i] = SLOT_W'(i % PALETTE_WORDS);
    end
    return t;
  endfunction

  localparam slot_tab_t SlotTab = build_slot_tab();

  typedef enum logic [2:0] {
    OP_SET_ADDR = 3'd0,
    OP_WRITE    = 3'd1,
    OP_READ     = 3'd2,
    OP_READ_H   = 3'd3,
    OP_READ_V   = 3'd4,
    OP_STATUS   = 3'd5,
    OP_LATCH    = 3'd6
  } op_e;

  // register index codes on the configuration port
  localparam logic REG_REGION  = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  localparam logic [3:0] CHIP_VERSION_RST = 4'd1;

  typedef struct packed {
    logic       region_pal;
    logic [3:0] chip_version;
  } cfg_t;

endpackage

// ===== hdl/palette_port_and_counter_readback_top.sv =====
// top level: stream ports, apb configuration registers and the operation engine
// depends on pprc_pkg, pprc_core (and through it pprc_ram)
// results: set address, write data and latch give no word;
//   read h, read v and status words sit in the result register in the cycle after acceptance;
//   palette read passes through the registered ram read port, then into the result register
// throughput: one word per cycle unless the result stream stalls; palette read holds the input while the ram reads
// reset: rst_ni is asynchronous, active low; the palette reads as zero after reset through
//   per-word valid flags, so there is no clearing pass and words are taken right away
module palette_port_and_counter_readback_top
  import pprc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte, [16:8] h_position, [25:17] v_position, [26] latch_enable,
  // [27] field_bit, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  // [2:0] opcode
  input  logic [2:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_byte
  output logic [7:0]  m_axis_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q, cfg_d;
  logic cfg_wr;
  logic reg_sel;

  assign pready  = 1'b1;
  // register index is the word address; byte offset bits are ignored
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_REGION:  cfg_d.region_pal   = pwdata[0];
        REG_VERSION: cfg_d.chip_version = pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_pal   <= 1'b0;
      cfg_q.chip_version <= CHIP_VERSION_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back the selected register, zero extended
  always_comb begin
    case (reg_sel)
      REG_REGION:  prdata = {31'd0, cfg_q.region_pal};
      REG_VERSION: prdata = {28'd0, cfg_q.chip_version};
      default:     prdata = '0;
    endcase
  end

  // operation engine with the palette ram and result register
  pprc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (s_axis_tuser),
    .in_data_i     (s_axis_tdata[7:0]),
    .in_h_i        (s_axis_tdata[16:8]),
    .in_v_i        (s_axis_tdata[25:17]),
    .in_latch_en_i (s_axis_tdata[26]),
    .in_field_i    (s_axis_tdata[27]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata)
  );

endmodule

// ===== hdl/pprc_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module pprc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pprc_core.sv =====
// operation engine: byte address, latches, beam counter capture, output register
// depends on pprc_pkg and pprc_ram
module pprc_core
  import pprc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] in_op_i,
  input  logic [7:0] in_data_i,
  input  logic [8:0] in_h_i,
  input  logic [8:0] in_v_i,
  input  logic       in_latch_en_i,
  input  logic       in_field_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [7:0]          hold_q, hold_d;
  logic [7:0]          latch_q, latch_d;
  logic                h_sec_q, h_sec_d;
  logic                v_sec_q, v_sec_d;
  logic [8:0]          hcap_q, hcap_d;
  logic [8:0]          vcap_q, vcap_d;
  logic                flag_q, flag_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                rd_hi_q, rd_hi_d;
  logic                rd_valid_q, rd_valid_d;
  logic [PALETTE_WORDS-1:0] valid_q;

  logic                accept;
  logic                ram_we, ram_re;
  slot_t               slot;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   word;
  logic [WORD_W-1:0]   wr_word;
  logic                status_six;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign slot       = SlotTab[addr_q[ADDR_W-1:1]];
  assign wr_word    = {in_data_i[6:0], hold_q};
  assign word       = rd_valid_q ? ram_rdata : '0;
  assign status_six = !in_latch_en_i || flag_q;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    hold_d      = hold_q;
    latch_d     = latch_q;
    h_sec_d     = h_sec_q;
    v_sec_d     = v_sec_q;
    hcap_d      = hcap_q;
    vcap_d      = vcap_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    rd_hi_d     = rd_hi_q;
    rd_valid_d  = rd_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (state_q == S_READ) begin
      // palette word arrives from the ram this cycle
      if (rd_hi_q) begin
        latch_d = {latch_q[7], word[14:8]};
      end else begin
        latch_d = word[7:0];
      end
      out_valid_d = 1'b1;
      out_byte_d  = latch_d;
      state_d     = S_IDLE;
    end else if (accept) begin
      case (op_e'(in_op_i))
        OP_SET_ADDR: begin
          addr_d = {in_data_i, 1'b0};
        end
        OP_WRITE: begin
          if (!addr_q[0]) begin
            hold_d = in_data_i;
          end else begin
            ram_we = 1'b1;
          end
          addr_d = addr_q + ADDR_W'(1);
        end
        OP_READ: begin
          ram_re     = 1'b1;
          rd_hi_d    = addr_q[0];
          rd_valid_d = valid_q[slot];
          addr_d     = addr_q + ADDR_W'(1);
          state_d    = S_READ;
        end
        OP_READ_H: begin
          latch_d     = h_sec_q ? {latch_q[7:1], hcap_q[8]} : hcap_q[7:0];
          h_sec_d     = !h_sec_q;
          out_valid_d = 1'b1;
          out_byte_d  = latch_d;
        end
        OP_READ_V: begin
          latch_d     = v_sec_q ? {latch_q[7:1], vcap_q[8]} : vcap_q[7:0];
          v_sec_d     = !v_sec_q;
          out_valid_d = 1'b1;
          out_byte_d  = latch_d;
        end
        OP_STATUS: begin
          h_sec_d = 1'b0;
          v_sec_d = 1'b0;
          if (in_latch_en_i && flag_q) begin
            flag_d = 1'b0;
          end
          latch_d     = {in_field_i, status_six, latch_q[5], cfg_i.region_pal,
                         cfg_i.chip_version};
          out_valid_d = 1'b1;
          out_byte_d  = latch_d;
        end
        OP_LATCH: begin
          if (in_latch_en_i) begin
            hcap_d = in_h_i;
            vcap_d = in_v_i;
            flag_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      addr_q      <= '0;
      hold_q      <= '0;
      latch_q     <= '0;
      h_sec_q     <= 1'b0;
      v_sec_q     <= 1'b0;
      hcap_q      <= '0;
      vcap_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      hold_q      <= hold_d;
      latch_q     <= latch_d;
      h_sec_q     <= h_sec_d;
      v_sec_q     <= v_sec_d;
      hcap_q      <= hcap_d;
      vcap_q      <= vcap_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        valid_q[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    rd_hi_q    <= rd_hi_d;
    rd_valid_q <= rd_valid_d;
  end

  pprc_ram #(
    .Width (WORD_W),
    .Depth (PALETTE_WORDS)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (wr_word),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // the result register must be free when the palette word comes back
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !out_valid_q)
    else $error("palette read finishes onto an occupied result register");

  a_read_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op_i == OP_READ)) |=> (state_q == S_READ))
    else $error("palette read did not wait for the ram");

  a_read_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> out_valid_q)
    else $error("palette read produced no word");

  a_flag_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op_i == OP_STATUS) && in_latch_en_i) |=> !flag_q)
    else $error("status read left the latch flag set");

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for the palette port and counter readback block
// drives access words on the input stream, predicts every read byte, checks the result stream
// depends on pprc_pkg and palette_port_and_counter_readback_top
module tb_top
  import pprc_pkg::*;
();

  // opcode 7 has no package name; the block must swallow it silently
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int unsigned HOLD_OFF_CYCLES = 400;  // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES   = 6;    // settle time for a trailing palette read
  localparam int unsigned WATCHDOG_LIMIT  = 3000; // cycles with no word moving
  localparam int unsigned PHASE_WORDS     = 530;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic [8:0] hpos;
    logic [8:0] vpos;
    logic       latch_en;
    logic       field;
  } port_access_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  palette_port_and_counter_readback_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // predicted state of the port, updated on every accepted access word
  // ------------------------------------------------------------------
  logic [14:0] pal_words [PALETTE_WORDS];
  logic [8:0]  byte_addr;
  logic [7:0]  low_hold;
  logic [7:0]  bus_latch;     // last byte driven onto the data bus
  logic        h_high_next;   // next h read gives bit 8
  logic        v_high_next;
  logic [8:0]  h_snap;
  logic [8:0]  v_snap;
  logic        snap_flag;
  logic        region_cfg;
  logic [3:0]  version_cfg;

  port_access_t pending_accesses [$];
  logic [7:0]   expected_bytes [$];
  port_access_t offered_access;

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned stall_asks   = 0;
  int unsigned stall_taken  = 0;
  int unsigned stall_left   = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  logic        recv_ready_next;

  // works out the byte, if any, that one access puts on the result stream
  function automatic void predict_read_byte(port_access_t acc);
    int unsigned slot;
    logic [7:0]  status;
    slot = (int'(byte_addr) >> 1) % PALETTE_WORDS;
    case (acc.op)
      OP_SET_ADDR: byte_addr = {acc.data, 1'b0};
      OP_WRITE: begin
        if (!byte_addr[0]) begin
          low_hold = acc.data;
        end else begin
          pal_words[slot] = {acc.data[6:0], low_hold};
        end
        byte_addr = byte_addr + 9'd1;
      end
      OP_READ: begin
        // high byte keeps bus bit 7, the word has only 15 bits
        if (!byte_addr[0]) begin
          bus_latch = pal_words[slot][7:0];
        end else begin
          bus_latch = {bus_latch[7], pal_words[slot][14:8]};
        end
        byte_addr = byte_addr + 9'd1;
        expected_bytes.push_back(bus_latch);
      end
      OP_READ_H: begin
        if (!h_high_next) begin
          bus_latch = h_snap[7:0];
        end else begin
          bus_latch = {bus_latch[7:1], h_snap[8]};
        end
        h_high_next = ~h_high_next;
        expected_bytes.push_back(bus_latch);
      end
      OP_READ_V: begin
        if (!v_high_next) begin
          bus_latch = v_snap[7:0];
        end else begin
          bus_latch = {bus_latch[7:1], v_snap[8]};
        end
        v_high_next = ~v_high_next;
        expected_bytes.push_back(bus_latch);
      end
      OP_STATUS: begin
        // flag bit is forced while the enable is low, else reports and clears the snapshot flag
        status = {acc.field, (!acc.latch_en || snap_flag), bus_latch[5], region_cfg, version_cfg};
        if (acc.latch_en) begin
          snap_flag = 1'b0;
        end
        h_high_next = 1'b0;
        v_high_next = 1'b0;
        bus_latch   = status;
        expected_bytes.push_back(status);
      end
      OP_LATCH: begin
        if (acc.latch_en) begin
          h_snap    = acc.hpos;
          v_snap    = acc.vpos;
          snap_flag = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic port_access_t make_access(logic [2:0] op, logic [7:0] data,
                                               logic [8:0] hpos, logic [8:0] vpos,
                                               logic latch_en, logic field);
    port_access_t a;
    a.op = op;
    a.data = data;
    a.hpos = hpos;
    a.vpos = vpos;
    a.latch_en = latch_en;
    a.field = field;
    return a;
  endfunction

  // mostly palette traffic around a few addresses so that reads hit written words
  function automatic port_access_t random_access();
    port_access_t a;
    int unsigned  pick;
    pick       = $urandom_range(99);
    a.data     = 8'($urandom);
    a.hpos     = 9'($urandom);
    a.vpos     = 9'($urandom);
    a.latch_en = ($urandom_range(3) != 0);
    a.field    = 1'($urandom);
    if (pick < 10) begin
      a.op = OP_SET_ADDR;
      if ($urandom_range(1) == 0) begin
        a.data = 8'($urandom_range(7));
      end
    end else if (pick < 38) begin
      a.op = OP_WRITE;
    end else if (pick < 62) begin
      a.op = OP_READ;
    end else if (pick < 73) begin
      a.op = OP_READ_H;
    end else if (pick < 84) begin
      a.op = OP_READ_V;
    end else if (pick < 92) begin
      a.op = OP_STATUS;
    end else if (pick < 98) begin
      a.op = OP_LATCH;
    end else begin
      a.op = OP_UNUSED;
    end
    return a;
  endfunction

  // ------------------------------------------------------------------
  // driver: offers words from the pending queue, predicts on acceptance
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_read_byte(offered_access);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          offered_access = pending_accesses.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, offered_access.field, offered_access.latch_en,
                            offered_access.vpos, offered_access.hpos, offered_access.data};
          s_axis_tuser  <= offered_access.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: checks each result word against the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected result word %h", m_axis_tdata);
          end
          errors++;
        end else if (expected_bytes[0] !== m_axis_tdata) begin
          if (errors < 10) begin
            $display("read_byte mismatch: expected %h, got %h", expected_bytes[0], m_axis_tdata);
          end
          errors++;
          void'(expected_bytes.pop_front());
        end else begin
          void'(expected_bytes.pop_front());
        end
      end
      // a long hold-off lets the block fill and push back on its input
      if (stall_asks != stall_taken) begin
        stall_taken = stall_asks;
        stall_left  = HOLD_OFF_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        recv_ready_next = 1'b0;
      end else begin
        recv_ready_next = ($urandom_range(99) >= recv_gap_pct);
      end
      m_axis_tready <= recv_ready_next;
    end
  end

  // watchdog on cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // register write with a setup and an access phase; the tb copy follows once the access cycle is done
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_REGION) begin
      region_cfg = value[0];
    end else begin
      version_cfg = value[3:0];
    end
  endtask

  // everything sent, everything back, then a settle wait for a trailing palette read
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_accesses.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                  input bit hold_off);
    @(negedge clk_i);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      pending_accesses.push_back(random_access());
    end
    if (hold_off) begin
      stall_asks++;
    end
    wait_idle();
  endtask

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  initial begin
    for (int i = 0; i < PALETTE_WORDS; i++) begin
      pal_words[i] = '0;
    end
    byte_addr   = '0;
    low_hold    = '0;
    bus_latch   = '0;
    h_high_next = 1'b0;
    v_high_next = 1'b0;
    h_snap      = '0;
    v_snap      = '0;
    snap_flag   = 1'b0;
    region_cfg  = 1'b0;
    version_cfg = CHIP_VERSION_RST;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // first the reset configuration is checked through status reads
    @(negedge clk_i);
    pending_accesses.push_back(make_access(OP_STATUS, 8'h00, 9'h000, 9'h000, 1'b0, 1'b1));
    pending_accesses.push_back(make_access(OP_READ_H, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_READ_H, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    // latch with the enable low must leave the snapshot alone
    pending_accesses.push_back(make_access(OP_LATCH, 8'h00, 9'h1ff, 9'h1ff, 1'b0, 1'b0));
    pending_accesses.push_back(make_access(OP_STATUS, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    wait_idle();

    cfg_write(REG_REGION, 32'd1);
    cfg_write(REG_VERSION, 32'd15);

    @(negedge clk_i);
    pending_accesses.push_back(make_access(OP_LATCH, 8'hff, 9'h1ff, 9'h100, 1'b1, 1'b1));
    pending_accesses.push_back(make_access(OP_READ_H, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_READ_H, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_READ_V, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_READ_V, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    // snapshot flag reported once, then cleared
    pending_accesses.push_back(make_access(OP_STATUS, 8'h00, 9'h000, 9'h000, 1'b1, 1'b1));
    pending_accesses.push_back(make_access(OP_STATUS, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    // status sends the counter toggles back to the low byte
    pending_accesses.push_back(make_access(OP_READ_H, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    // top of the palette, address wraps past 511 back to zero
    pending_accesses.push_back(make_access(OP_SET_ADDR, 8'hff, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_WRITE, 8'hff, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_WRITE, 8'hff, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_SET_ADDR, 8'hff, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_READ, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_READ, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    // bit 5 of the bus latch leaks into status
    pending_accesses.push_back(make_access(OP_STATUS, 8'h00, 9'h000, 9'h000, 1'b1, 1'b1));
    pending_accesses.push_back(make_access(OP_READ, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    // odd-byte write straight after a read, using the older held low byte
    pending_accesses.push_back(make_access(OP_WRITE, 8'h80, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_UNUSED, 8'hff, 9'h1ff, 9'h1ff, 1'b1, 1'b1));
    pending_accesses.push_back(make_access(OP_SET_ADDR, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_READ, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    pending_accesses.push_back(make_access(OP_READ, 8'h00, 9'h000, 9'h000, 1'b1, 1'b0));
    wait_idle();

    cfg_write(REG_REGION, 32'd0);
    cfg_write(REG_VERSION, 32'd0);
    run_random_phase(16, 66, 1'b0);

    cfg_write(REG_REGION, 32'd1);
    cfg_write(REG_VERSION, 32'($urandom_range(15)));
    run_random_phase(66, 16, 1'b0);

    cfg_write(REG_REGION, 32'd0);
    cfg_write(REG_VERSION, 32'd15);
    run_random_phase(0, 0, 1'b1);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
